@@ hw/rtl/fpbf_pkg.sv @@
// Shared types and constants for the fixed-partition best-fit allocator.
package fpbf_pkg;

    localparam int unsigned MAX_SLOTS = 16;

    typedef logic [9:0] t_mb;

    // Partition sizes in MB; slots past the ninth are empty.
    localparam t_mb PART_SIZE [MAX_SLOTS] = '{
        10'd256, 10'd256, 10'd512, 10'd512, 10'd512, 10'd512, 10'd640, 10'd512,
        10'd384, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0
    };

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_NO_FIT     = 3'd1;
    localparam logic [2:0] STAT_POOL_SHORT = 3'd2;
    localparam logic [2:0] STAT_BAD_NUM    = 3'd3;
    localparam logic [2:0] STAT_NOT_HELD   = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [15:0] request_size;
        logic [3:0]  partition_number;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  chosen_partition;
        logic [9:0]  fragment_mb;
        logic [9:0]  freed_mb;
        logic [12:0] used_mb;
        logic [3:0]  usage_tenths;
    } t_rsp;

endpackage

@@ hw/rtl/fpbf_stream_if.sv @@
// Valid/ready channel carrying one payload item per transfer.
interface fpbf_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/fixed_partition_best_fit.sv @@
// Fixed-partition best-fit allocator: request channel in, one result per request out.
//
// i_req carries allocate and free requests (fpbf_pkg::t_req), o_rsp carries
// one result per request (fpbf_pkg::t_rsp); both move on valid and ready high.
// An allocate walks the partitions with one shared subtract/compare unit, one
// partition per cycle, then decides and commits in S_DECIDE before o_rsp.valid
// rises in S_OUT. A free reads and updates its partition in S_FREE, then raises
// valid in S_OUT; for a bad partition number valid is up right after the
// transfer. One request is worked on at a time; a new request is taken in the
// cycle its predecessor's result transfers.
// Synchronous reset marks every partition free and sets the pool counter to
// POOL_MB; no clearing pass is needed.
// While the receiver stalls the result is held and no request is accepted.
// used_mb and usage_tenths report the pool after the request, also on failure.
module fixed_partition_best_fit #(
    parameter int unsigned NUM_PARTITIONS = 9,
    parameter int unsigned POOL_MB        = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fpbf_stream_if.sink         i_req,
    fpbf_stream_if.source       o_rsp
);
    import fpbf_pkg::*;

    localparam int unsigned IDX_W  = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int unsigned POOL_W = $clog2(POOL_MB + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_PARTITIONS - 1);
    localparam logic [POOL_W-1:0] POOL_FULL = POOL_W'(POOL_MB);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FREE   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [NUM_PARTITIONS-1:0] r_occ;
    t_mb                       r_held [NUM_PARTITIONS];
    logic [POOL_W-1:0]         r_pool_free;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          r_best;
    t_mb                       r_best_frag;
    logic                      r_found;
    logic [15:0]               r_req_size;
    logic [3:0]                r_num;
    logic [2:0]                r_status;
    logic [3:0]                r_chosen;
    t_mb                       r_frag;
    t_mb                       r_freed;

    logic              w_take;
    logic              w_give;
    logic              w_bad_num;
    t_mb               w_size;
    logic              w_fit;
    t_mb               w_diff;
    logic              w_better;
    logic              w_short;
    logic [POOL_W-1:0] w_used;
    logic [9:0]        w_hit;
    logic [3:0]        w_tenths;

    assign w_give = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) || ((r_state == S_OUT) && o_rsp.ready);
    assign w_take = i_req.valid && i_req.ready;

    assign w_bad_num = (i_req.data.partition_number == 4'd0) ||
                       ({1'b0, i_req.data.partition_number} > 5'(NUM_PARTITIONS));

    // Shared subtract/compare unit: fit and leftover of the partition under scan
    assign w_size   = PART_SIZE[4'(r_idx)];
    assign w_fit    = !r_occ[r_idx] && ({6'd0, w_size} >= r_req_size);
    assign w_diff   = w_size - r_req_size[9:0];
    assign w_better = w_fit && (!r_found || (w_diff < r_best_frag));
    assign w_short  = r_req_size > 16'(r_pool_free);

    assign w_used = (r_pool_free < POOL_FULL) ? (POOL_FULL - r_pool_free) : '0;

    // Tenths of use: count the thresholds ceil(k*POOL_MB/10) reached
    for (genvar k = 1; k <= 10; k++) begin : g_tenth
        localparam logic [POOL_W-1:0] TH = POOL_W'((k * POOL_MB + 9) / 10);
        assign w_hit[k-1] = (w_used >= TH);
    end

    always_comb begin
        w_tenths = '0;
        for (int k = 0; k < 10; k++) begin
            w_tenths = w_tenths + 4'(w_hit[k]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_OUT: begin
                if (w_take) begin
                    if (i_req.data.req_type == REQ_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (w_bad_num) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_FREE;
                    end
                end else if (w_give) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE, S_FREE: n_state = S_OUT;
            default:          n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_pool_free <= POOL_FULL;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE, S_OUT: begin
                    if (w_take) begin
                        r_req_size <= i_req.data.request_size;
                        r_num      <= i_req.data.partition_number;
                        r_found    <= 1'b0;
                        r_chosen   <= '0;
                        r_frag     <= '0;
                        r_freed    <= '0;
                        if (i_req.data.req_type == REQ_ALLOC) begin
                            r_idx <= '0;
                        end else begin
                            r_idx    <= IDX_W'(i_req.data.partition_number - 4'd1);
                            r_status <= STAT_BAD_NUM;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_better) begin
                        r_found     <= 1'b1;
                        r_best      <= r_idx;
                        r_best_frag <= w_diff;
                    end
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_DECIDE: begin
                    if (!r_found) begin
                        r_status <= STAT_NO_FIT;
                    end else if (w_short) begin
                        r_status <= STAT_POOL_SHORT;
                    end else begin
                        r_status       <= STAT_OK;
                        r_occ[r_best]  <= 1'b1;
                        r_held[r_best] <= r_req_size[9:0];
                        r_pool_free    <= r_pool_free - POOL_W'(r_req_size);
                        r_chosen       <= 4'(r_best) + 4'd1;
                        r_frag         <= r_best_frag;
                    end
                end
                S_FREE: begin
                    if (!r_occ[r_idx]) begin
                        r_status <= STAT_NOT_HELD;
                    end else begin
                        r_status      <= STAT_OK;
                        r_occ[r_idx]  <= 1'b0;
                        r_freed       <= r_held[r_idx];
                        r_pool_free   <= r_pool_free + POOL_W'(r_held[r_idx]);
                        r_chosen      <= r_num;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.valid                 = (r_state == S_OUT);
    assign o_rsp.data.status           = r_status;
    assign o_rsp.data.chosen_partition = r_chosen;
    assign o_rsp.data.fragment_mb      = r_frag;
    assign o_rsp.data.freed_mb         = r_freed;
    assign o_rsp.data.used_mb          = 13'(w_used);
    assign o_rsp.data.usage_tenths     = w_tenths;

`ifndef NO_ASSERTIONS
    a_ok_names_partition: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.data.status == STAT_OK)) |-> (o_rsp.data.chosen_partition != 4'd0))
        else $error("successful result without a partition");

    a_pool_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_free <= POOL_FULL)
        else $error("pool counter above pool size");

    a_stall_holds_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> $stable(r_pool_free))
        else $error("pool changed while result stalled");

    a_fail_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.data.status != STAT_OK)) |->
        ((o_rsp.data.fragment_mb == 10'd0) && (o_rsp.data.freed_mb == 10'd0)))
        else $error("failed request reports sizes");
`endif

endmodule
